>>> rtl/core/cfalu_pkg.sv
// ----------------------------------------------------------------------------
// cfalu_pkg
// Shared types and opcode constants for the 32/64-bit integer ALU.
// ----------------------------------------------------------------------------
package cfalu_pkg;

    // one quotient bit per divider stage, 64-bit dividend
    localparam int unsigned DivStages = 64;

    typedef enum logic [5:0] {
        OP_MOVE   = 6'd0,  OP_SELECT = 6'd1,  OP_SCAST  = 6'd2,  OP_ZCAST  = 6'd3,
        OP_SEXT8  = 6'd4,  OP_SEXT16 = 6'd5,  OP_ADD    = 6'd6,  OP_SUB    = 6'd7,
        OP_NEG    = 6'd8,  OP_MUL    = 6'd9,  OP_MULHU  = 6'd10, OP_MULHS  = 6'd11,
        OP_DIVU   = 6'd12, OP_DIVS   = 6'd13, OP_MODU   = 6'd14, OP_MODS   = 6'd15,
        OP_AND    = 6'd16, OP_OR     = 6'd17, OP_XOR    = 6'd18, OP_NOT    = 6'd19,
        OP_SLL    = 6'd20, OP_SRL    = 6'd21, OP_SRA    = 6'd22, OP_ROL    = 6'd23,
        OP_ROR    = 6'd24, OP_CLZ    = 6'd25, OP_BSWAP  = 6'd26, OP_SEQ    = 6'd27,
        OP_SLTU   = 6'd28, OP_SLTS   = 6'd29, OP_SGTU   = 6'd30, OP_SGTS   = 6'd31,
        OP_BFEXT  = 6'd32, OP_BFINS  = 6'd33
    } op_t;

    // Operation classes chosen by the front end
    typedef enum logic [1:0] {
        CLS_SIMPLE = 2'd0,
        CLS_MUL    = 2'd1,
        CLS_DIV    = 2'd2
    } cls_t;

    // Decoded item travelling from front end to back end
    typedef struct packed {
        cls_t        cls;
        logic        is_64;
        logic        mul_hi;     // high half wanted
        logic        sgn;        // signed mul/div
        logic        want_rem;   // div: remainder
        logic        div_zero;   // forced zero result
        logic        neg_q;      // negate quotient/remainder
        logic [63:0] a;          // simple result, or mul/div first operand
        logic [63:0] b;
    } dec_t;

endpackage

>>> rtl/core/constant_fold_alu.sv
// ----------------------------------------------------------------------------
// constant_fold_alu
// 32/64-bit integer ALU with a decoding front end, a decoupling queue and a
// pipelined multiply/divide back end.
// ----------------------------------------------------------------------------
// channel  | direction | handshake            | payload
// input    | in        | push / full          | mode, is_64, operand_a/b/c,
//          |           |                      | field_start, field_count
// result   | out       | empty / pop          | result
//
// One transaction enters per cycle while full is low. Every operation, simple
// ones too, passes through the queue and the whole divider-depth pipeline,
// so results leave in order.
// The queue holds four decoded items; full rises when it fills while the
// pipeline is held by a result not popped. Reset clears the queue pointers
// and pipeline valid bits only.
// ----------------------------------------------------------------------------
module constant_fold_alu (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [5:0]  mode,
    input  logic        is_64,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    input  logic [63:0] operand_c,
    input  logic [5:0]  field_start,
    input  logic [5:0]  field_count,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] result
);
    import cfalu_pkg::*;

    dec_t dec, q_dec;
    logic q_empty, q_rd, stall, out_valid;

    cfalu_front u_front (
        .mode        (mode),
        .is_64       (is_64),
        .operand_a   (operand_a),
        .operand_b   (operand_b),
        .operand_c   (operand_c),
        .field_start (field_start),
        .field_count (field_count),
        .dec         (dec)
    );

    cfalu_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && !full),
        .wr_data (dec),
        .full    (full),
        .rd_en   (q_rd),
        .rd_data (q_dec),
        .empty   (q_empty)
    );

    // back end takes from the queue whenever its pipeline moves
    assign q_rd = !q_empty && !stall;

    cfalu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_rd),
        .in_dec     (q_dec),
        .stall      (stall),
        .out_valid  (out_valid),
        .out_result (result),
        .out_ready  (pop)
    );

    assign empty = !out_valid;

endmodule

>>> rtl/core/cfalu_front.sv
// ----------------------------------------------------------------------------
// cfalu_front
// Decodes an item, computes the simple operations and classifies the
// rest for the multiply and divide back end.
// ----------------------------------------------------------------------------
module cfalu_front (
    input  logic              [5:0]  mode,
    input  logic                     is_64,
    input  logic              [63:0] operand_a,
    input  logic              [63:0] operand_b,
    input  logic              [63:0] operand_c,
    input  logic              [5:0]  field_start,
    input  logic              [5:0]  field_count,
    output cfalu_pkg::dec_t          dec
);
    import cfalu_pkg::*;

    logic [63:0] wm, ua, ub, sa, sb, r, fm, bm, sra_v, rot_v, rl_v;
    logic [5:0]  sh, rsh, ln;
    logic [6:0]  wid;
    logic        start_ok, na, nb, minv;
    logic [63:0] ma, mb;

    always_comb
    begin
        wm    = is_64 ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
        wid   = is_64 ? 7'd64 : 7'd32;
        ua    = operand_a & wm;
        ub    = operand_b & wm;
        sa    = is_64 ? operand_a : {{32{operand_a[31]}}, operand_a[31:0]};
        sb    = is_64 ? operand_b : {{32{operand_b[31]}}, operand_b[31:0]};
        sh    = is_64 ? operand_b[5:0] : {1'b0, operand_b[4:0]};
        rsh   = is_64 ? (6'd0 - operand_b[5:0]) : {1'b0, 5'(5'd0 - operand_b[4:0])};
        sra_v = $unsigned($signed(sa) >>> sh);
        rl_v  = '0;
        rot_v = '0;
        ln    = '0;
        r     = '0;
        dec   = '0;
        dec.is_64 = is_64;

        start_ok = ({1'b0, field_start} < wid);
        fm = ({1'b0, field_count} >= wid) ? wm : ((64'd1 << field_count) - 64'd1);
        bm = start_ok ? ((fm << field_start) & wm) : 64'd0;

        na = sa[63];
        nb = sb[63];
        ma = na ? (64'd0 - sa) : sa;
        mb = nb ? (64'd0 - sb) : sb;
        minv = is_64 ? (operand_a == 64'h8000_0000_0000_0000)
                     : (operand_a[31:0] == 32'h8000_0000);

        case (mode)
            OP_MOVE:   r = operand_a;
            OP_SELECT: r = (operand_c != 64'd0) ? operand_a : operand_b;
            OP_SCAST:  r = sa;
            OP_ZCAST:  r = ua;
            OP_SEXT8:  r = {{56{operand_a[7]}}, operand_a[7:0]};
            OP_SEXT16: r = {{48{operand_a[15]}}, operand_a[15:0]};
            OP_ADD:    r = operand_a + operand_b;
            OP_SUB:    r = operand_a - operand_b;
            OP_NEG:    r = 64'd0 - operand_a;
            OP_AND:    r = operand_a & operand_b;
            OP_OR:     r = operand_a | operand_b;
            OP_XOR:    r = operand_a ^ operand_b;
            OP_NOT:    r = ~operand_a;
            OP_SLL:    r = ua << sh;
            OP_SRL:    r = ua >> sh;
            OP_SRA:    r = sra_v;
            OP_ROL, OP_ROR:
            begin
                rl_v = (mode == OP_ROL) ? {58'd0, rsh} : {58'd0, sh};
                if (is_64)
                    rot_v = (ua >> rl_v[5:0]) | (ua << (7'd64 - {1'b0, rl_v[5:0]}));
                else
                    rot_v = {32'd0, (ua[31:0] >> rl_v[4:0])
                                  | 32'(ua[31:0] << (6'd32 - {1'b0, rl_v[4:0]}))};
                r = (rl_v[5:0] == 6'd0) ? ua : rot_v;
            end
            OP_CLZ:
            begin
                ln = 6'd0;
                for (int i = 0; i < 64; i++)
                    if (ua[i]) ln = 6'(63 - i);
                r = (ua == 64'd0) ? {57'd0, wid} :
                    (is_64 ? {58'd0, ln} : {58'd0, 6'(ln - 6'd32)});
            end
            OP_BSWAP:
            begin
                for (int i = 0; i < 8; i++)
                    r[8*i +: 8] = ua[56 - 8*i +: 8];
                if (!is_64)
                    r = {32'd0, ua[7:0], ua[15:8], ua[23:16], ua[31:24]};
            end
            OP_SEQ:    r = {63'd0, ua == ub};
            OP_SLTU:   r = {63'd0, ua < ub};
            OP_SLTS:   r = {63'd0, $signed(sa) < $signed(sb)};
            OP_SGTU:   r = {63'd0, ua > ub};
            OP_SGTS:   r = {63'd0, $signed(sb) < $signed(sa)};
            OP_BFEXT:  r = start_ok ? ((ua >> field_start) & fm) : 64'd0;
            OP_BFINS:  r = (operand_a & ~bm) | ((operand_b << field_start) & bm);
            OP_MUL, OP_MULHU, OP_MULHS:
            begin
                dec.cls    = CLS_MUL;
                dec.mul_hi = (mode != OP_MUL);
                dec.sgn    = (mode == OP_MULHS);
            end
            OP_DIVU, OP_MODU, OP_DIVS, OP_MODS:
            begin
                dec.cls      = CLS_DIV;
                dec.want_rem = (mode == OP_MODU) || (mode == OP_MODS);
                dec.sgn      = (mode == OP_DIVS) || (mode == OP_MODS);
            end
            default:   r = 64'd0;
        endcase

        if (dec.cls == CLS_SIMPLE)
        begin
            // casts keep their full width
            dec.a = ((mode == OP_SCAST) || (mode == OP_ZCAST)) ? r : (r & wm);
        end
        else if (dec.cls == CLS_MUL)
        begin
            dec.a = operand_a;
            dec.b = operand_b;
        end
        else if (dec.sgn)
        begin
            dec.a        = ma;
            dec.b        = mb;
            dec.div_zero = (ub == 64'd0) || (minv && (sb == '1));
            dec.neg_q    = dec.want_rem ? na : (na != nb);
        end
        else
        begin
            dec.a        = ua;
            dec.b        = ub;
            dec.div_zero = (ub == 64'd0);
        end
    end

endmodule

>>> rtl/core/cfalu_fifo.sv
// ----------------------------------------------------------------------------
// cfalu_fifo
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module cfalu_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  cfalu_pkg::dec_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output cfalu_pkg::dec_t rd_data,
    output logic            empty
);
    import cfalu_pkg::*;

    dec_t       mem_reg [4];
    logic [1:0] wp_reg, rp_reg, wp_next, rp_next;
    logic [2:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == 3'd4);
    assign empty   = (cnt_reg == 3'd0);
    assign rd_data = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg + 2'(wr_en);
        rp_next  = rp_reg + 2'(rd_en);
        cnt_next = cnt_reg + 3'(wr_en) - 3'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> rtl/core/cfalu_back.sv
// ----------------------------------------------------------------------------
// cfalu_back
// Pipelined back end: 4-stage 32x32 partial-product multiplier and a
// radix-2 divider unrolled over 64 pipeline stages, one bit per stage.
// ----------------------------------------------------------------------------
module cfalu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  cfalu_pkg::dec_t in_dec,
    output logic            stall,
    output logic            out_valid,
    output logic [63:0]     out_result,
    input  logic            out_ready
);
    import cfalu_pkg::*;

    localparam int unsigned Depth = DivStages + 2;

    // Every item flows through a common shift pipeline so order is kept.
    typedef struct packed {
        dec_t         d;
        logic [63:0]  rem;
        logic [63:0]  quo;
        logic [127:0] acc;
    } stg_t;

    stg_t        pipe_reg  [Depth];
    logic        vld_reg   [Depth];
    stg_t        pipe_next [Depth];
    logic        adv;
    logic [64:0] trial;
    logic [63:0] hi, lo, res;
    logic [63:0] pa, pb;

    assign adv   = !(vld_reg[Depth-1] && !out_ready);
    assign stall = !adv;
    assign out_valid = vld_reg[Depth-1];
    assign out_result = res;

    always_comb
    begin
        for (int s = 0; s < Depth; s++)
            pipe_next[s] = '0;
        trial = '0;
        pa    = '0;
        pb    = '0;

        // stage 0: load operands; 32-bit dividends arrive zero-extended
        pipe_next[0].d   = in_dec;
        pipe_next[0].rem = '0;
        pipe_next[0].quo = in_dec.a;
        pipe_next[0].acc = '0;

        for (int s = 1; s < Depth; s++)
        begin
            pipe_next[s] = pipe_reg[s-1];
            if (s <= DivStages && pipe_reg[s-1].d.cls == CLS_DIV)
            begin
                trial = {pipe_reg[s-1].rem, pipe_reg[s-1].quo[63]}
                      - {1'b0, pipe_reg[s-1].d.b};
                if (!trial[64])
                begin
                    pipe_next[s].rem = trial[63:0];
                    pipe_next[s].quo = {pipe_reg[s-1].quo[62:0], 1'b1};
                end
                else
                begin
                    pipe_next[s].rem = {pipe_reg[s-1].rem[62:0], pipe_reg[s-1].quo[63]};
                    pipe_next[s].quo = {pipe_reg[s-1].quo[62:0], 1'b0};
                end
            end
            else if (s <= 4 && pipe_reg[s-1].d.cls == CLS_MUL)
            begin
                // one 32x32 partial product per stage
                pa = pipe_reg[s-1].d.a;
                pb = pipe_reg[s-1].d.b;
                if (!pipe_reg[s-1].d.is_64)
                begin
                    pa = pipe_reg[s-1].d.sgn ? {{32{pa[31]}}, pa[31:0]} : {32'd0, pa[31:0]};
                    pb = pipe_reg[s-1].d.sgn ? {{32{pb[31]}}, pb[31:0]} : {32'd0, pb[31:0]};
                end
                case (s)
                    1: pipe_next[s].acc = pipe_reg[s-1].acc
                                        + {64'd0, {32'd0, pa[31:0]} * {32'd0, pb[31:0]}};
                    2: pipe_next[s].acc = pipe_reg[s-1].acc
                                        + {32'd0, {32'd0, pa[31:0]} * {32'd0, pb[63:32]},
                                           32'd0};
                    3: pipe_next[s].acc = pipe_reg[s-1].acc
                                        + {32'd0, {32'd0, pa[63:32]} * {32'd0, pb[31:0]},
                                           32'd0};
                    4: pipe_next[s].acc = pipe_reg[s-1].acc
                                        + {{32'd0, pa[63:32]} * {32'd0, pb[63:32]}, 64'd0};
                    default: pipe_next[s].acc = pipe_reg[s-1].acc;
                endcase
            end
        end
    end

    // result formatting at the last stage
    always_comb
    begin
        hi  = pipe_reg[Depth-1].acc[127:64];
        lo  = pipe_reg[Depth-1].acc[63:0];
        res = pipe_reg[Depth-1].d.a;
        case (pipe_reg[Depth-1].d.cls)
            CLS_MUL:
            begin
                if (!pipe_reg[Depth-1].d.mul_hi)
                    res = lo;
                else if (pipe_reg[Depth-1].d.is_64)
                    res = hi - (pipe_reg[Depth-1].d.sgn && pipe_reg[Depth-1].d.a[63]
                                ? pipe_reg[Depth-1].d.b : 64'd0)
                             - (pipe_reg[Depth-1].d.sgn && pipe_reg[Depth-1].d.b[63]
                                ? pipe_reg[Depth-1].d.a : 64'd0);
                else
                    res = {32'd0, lo[63:32]};
            end
            CLS_DIV:
            begin
                res = pipe_reg[Depth-1].d.want_rem ? pipe_reg[Depth-1].rem
                                                   : pipe_reg[Depth-1].quo;
                if (pipe_reg[Depth-1].d.neg_q)
                    res = 64'd0 - res;
                if (pipe_reg[Depth-1].d.div_zero)
                    res = 64'd0;
            end
            default: res = pipe_reg[Depth-1].d.a;
        endcase
        if (!pipe_reg[Depth-1].d.is_64)
            res = {32'd0, res[31:0]};
        if (pipe_reg[Depth-1].d.cls == CLS_SIMPLE)
            res = pipe_reg[Depth-1].d.a;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            for (int s = 0; s < Depth; s++)
                pipe_reg[s] <= pipe_next[s];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < Depth; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < Depth; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

endmodule

>>> tb/constant_fold_alu_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// constant_fold_alu_tb
// Drives directed and random operations through the ALU queue interface and
// checks every result against a typed-in value or an in-bench prediction, with random
// stalls on both sides and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module constant_fold_alu_tb;
    import cfalu_pkg::*;

    localparam int NumRandom = 530;
    localparam int DrainCycles = 80;    // back-end pipeline depth plus margin
    localparam logic [5:0] OpUnused = 6'd63;

    typedef struct {
        logic [5:0]  op;
        logic        w64;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [5:0]  start;
        logic [5:0]  count;
        logic        has_exp;   // typed-in value present
        logic [63:0] exp;
    } alu_txn_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [5:0]  mode;
    logic        is_64;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic [63:0] operand_c;
    logic [5:0]  field_start;
    logic [5:0]  field_count;
    logic        empty;
    logic        pop;
    logic [63:0] result;

    logic [63:0] pending_results[$];
    int          mismatch_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off;

    constant_fold_alu u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .mode        (mode),
        .is_64       (is_64),
        .operand_a   (operand_a),
        .operand_b   (operand_b),
        .operand_c   (operand_c),
        .field_start (field_start),
        .field_count (field_count),
        .empty       (empty),
        .pop         (pop),
        .result      (result)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Sign-extend the low n bits of v
    function automatic logic [63:0] sext_low(logic [63:0] v, int n);
        logic [63:0] m;
        m = (n == 64) ? '1 : ((64'd1 << n) - 64'd1);
        v = v & m;
        if (n < 64 && v[n-1])
            v = v | ~m;
        return v;
    endfunction

    // Expected ALU output for one operation
    function automatic logic [63:0] alu_predict(alu_txn_t t);
        logic [63:0]  wm, ua, ub, sa, sb, r, fm, msk, ma, mb, q;
        logic [127:0] prod;
        int           w, sh, rn;
        logic         na, nb;
        w  = t.w64 ? 64 : 32;
        wm = t.w64 ? '1 : 64'hFFFF_FFFF;
        ua = t.a & wm;
        ub = t.b & wm;
        sa = t.w64 ? t.a : sext_low(t.a, 32);
        sb = t.w64 ? t.b : sext_low(t.b, 32);
        sh = int'(t.b & (w - 1));
        r  = '0;
        case (t.op)
            OP_MOVE:   r = t.a;
            OP_SELECT: r = (t.c != 0) ? t.a : t.b;
            OP_SCAST:  return sa;   // casts are never truncated
            OP_ZCAST:  return ua;
            OP_SEXT8:  r = sext_low(t.a, 8);
            OP_SEXT16: r = sext_low(t.a, 16);
            OP_ADD:    r = t.a + t.b;
            OP_SUB:    r = t.a - t.b;
            OP_NEG:    r = -t.a;
            OP_MUL:    r = t.a * t.b;
            OP_MULHU:
            begin
                prod = {64'd0, ua} * {64'd0, ub};
                r = t.w64 ? prod[127:64] : prod[95:32];
            end
            OP_MULHS:
            begin
                prod = $signed({{64{sa[63]}}, sa}) * $signed({{64{sb[63]}}, sb});
                r = t.w64 ? prod[127:64] : prod[95:32];
            end
            OP_DIVU:   r = (ub != 0) ? ua / ub : '0;
            OP_MODU:   r = (ub != 0) ? ua % ub : '0;
            OP_DIVS, OP_MODS:
            begin
                if (ub == 0 || (sa == sext_low(64'h8000_0000_0000_0000 >> (64 - w), w)
                                && sb == '1))
                    r = '0;
                else
                begin
                    na = sa[63];
                    nb = sb[63];
                    ma = na ? -sa : sa;
                    mb = nb ? -sb : sb;
                    if (t.op == OP_DIVS)
                    begin
                        q = ma / mb;
                        r = (na != nb) ? -q : q;
                    end
                    else
                    begin
                        q = ma % mb;
                        r = na ? -q : q;
                    end
                end
            end
            OP_AND:    r = t.a & t.b;
            OP_OR:     r = t.a | t.b;
            OP_XOR:    r = t.a ^ t.b;
            OP_NOT:    r = ~t.a;
            OP_SLL:    r = ua << sh;
            OP_SRL:    r = ua >> sh;
            OP_SRA:    r = $signed(sa) >>> sh;
            OP_ROL, OP_ROR:
            begin
                rn = (t.op == OP_ROR) ? sh : int'((-t.b) & (w - 1));
                r = (rn == 0) ? ua : (((ua >> rn) | (ua << (w - rn))) & wm);
            end
            OP_CLZ:
            begin
                r = 64'(w);
                for (int i = 0; i < w; i++)
                    if (ua[i])
                        r = 64'(w - 1 - i);
            end
            OP_BSWAP:
            begin
                for (int i = 0; i < w / 8; i++)
                    r = (r << 8) | ((ua >> (8 * i)) & 64'hFF);
            end
            OP_SEQ:    r = {63'd0, ua == ub};
            OP_SLTU:   r = {63'd0, ua < ub};
            OP_SLTS:   r = {63'd0, $signed(sa) < $signed(sb)};
            OP_SGTU:   r = {63'd0, ua > ub};
            OP_SGTS:   r = {63'd0, $signed(sb) < $signed(sa)};
            OP_BFEXT, OP_BFINS:
            begin
                fm = (t.count >= w) ? wm : ((64'd1 << t.count) - 64'd1);
                if (t.op == OP_BFEXT)
                    r = (t.start >= w) ? '0 : ((ua >> t.start) & fm);
                else
                begin
                    msk = (t.start >= w) ? '0 : ((fm << t.start) & wm);
                    r = (t.a & ~msk) | ((t.b << t.start) & msk);
                end
            end
            default:   r = '0;
        endcase
        return r & wm;
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            2: v = 64'h8000_0000_0000_0000;
            3: v = {32'd0, 32'h8000_0000};
            4: v = 64'(signed'($urandom_range(0, 8)) - 4);
            5: v = {{32{v[31]}}, v[31:0]};
            default: ;
        endcase
        return v;
    endfunction

    function automatic alu_txn_t make_op(logic [5:0] op, logic w64, logic [63:0] a,
                                          logic [63:0] b, logic [63:0] c,
                                          logic [5:0] start, logic [5:0] count,
                                          logic has_exp, logic [63:0] exp);
        alu_txn_t t;
        t.op = op; t.w64 = w64; t.a = a; t.b = b; t.c = c;
        t.start = start; t.count = count; t.has_exp = has_exp; t.exp = exp;
        return t;
    endfunction

    // Offer one transaction and wait until the block takes it
    task automatic send_op(alu_txn_t t);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        mode        <= t.op;
        is_64       <= t.w64;
        operand_a   <= t.a;
        operand_b   <= t.b;
        operand_c   <= t.c;
        field_start <= t.start;
        field_count <= t.count;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_results.push_back(t.has_exp ? t.exp : alu_predict(t));
    endtask

    // Result side: random pop, compare accepted result with oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %h", result);
                end
                else if (pending_results[0] !== result)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %h actual %h",
                                 pending_results[0], result);
                    void'(pending_results.pop_front());
                end
                else
                    void'(pending_results.pop_front());
            end
            pop <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
        end
        else
            pop <= 1'b0;
    end

    // Long receiver hold-off, counted in cycles, so the queue fills and full rises
    initial
    begin
        hold_off = 1'b0;
        wait (rst_n);
        repeat (150) @(posedge clk);
        hold_off <= 1'b1;
        repeat (200) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Overall limit
    initial
    begin
        #3ms;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        alu_txn_t    dir_ops[$];
        alu_txn_t    t;
        int          n;
        logic [63:0] mn;
        mn = 64'h8000_0000_0000_0000;

        rst_n = 1'b0; push = 1'b0; mode = '0; is_64 = 1'b0;
        operand_a = '0; operand_b = '0; operand_c = '0;
        field_start = '0; field_count = '0;
        mismatch_count = 0;
        send_idle_pct = 19; recv_idle_pct = 76;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: extremes, selected opcodes, special cases
        dir_ops.push_back(make_op(OP_MOVE, 1'b1, '1, 64'd0, 64'd0, 6'd0, 6'd0, 1'b1, '1));
        dir_ops.push_back(make_op(OP_MOVE, 1'b0, '1, 64'd0, 64'd0, 6'd0, 6'd0, 1'b1,
                                  64'hFFFF_FFFF));
        dir_ops.push_back(make_op(OP_SCAST, 1'b0, 64'h8000_0000, 64'd0, 64'd0, 6'd0, 6'd0,
                                  1'b1, 64'hFFFF_FFFF_8000_0000));
        dir_ops.push_back(make_op(OP_ZCAST, 1'b0, '1, 64'd0, 64'd0, 6'd0, 6'd0, 1'b1,
                                  64'hFFFF_FFFF));
        // zero divisor
        dir_ops.push_back(make_op(OP_DIVU, 1'b1, 64'd5, 64'd0, 64'd0, 6'd0, 6'd0, 1'b1,
                                  64'd0));
        dir_ops.push_back(make_op(OP_MODS, 1'b1, 64'd5, 64'd0, 64'd0, 6'd0, 6'd0, 1'b1,
                                  64'd0));
        // signed overflow, and a remainder by one
        dir_ops.push_back(make_op(OP_DIVS, 1'b1, mn, '1, 64'd0, 6'd0, 6'd0, 1'b1, 64'd0));
        dir_ops.push_back(make_op(OP_DIVS, 1'b0, 64'h8000_0000, '1, 64'd0, 6'd0, 6'd0,
                                  1'b1, 64'd0));
        dir_ops.push_back(make_op(OP_MODS, 1'b1, 64'd7, 64'd1, 64'd0, 6'd0, 6'd0, 1'b1,
                                  64'd0));
        // clz of zero
        dir_ops.push_back(make_op(OP_CLZ, 1'b1, 64'd0, 64'd0, 64'd0, 6'd0, 6'd0, 1'b1,
                                  64'd64));
        dir_ops.push_back(make_op(OP_CLZ, 1'b0, 64'd0, 64'd0, 64'd0, 6'd0, 6'd0, 1'b1,
                                  64'd32));
        // field start past the width, then a nearly full-width extract
        dir_ops.push_back(make_op(OP_BFEXT, 1'b0, '1, 64'd0, 64'd0, 6'd40, 6'd8, 1'b1,
                                  64'd0));
        dir_ops.push_back(make_op(OP_BFINS, 1'b0, '1, 64'd0, 64'd0, 6'd40, 6'd8, 1'b1,
                                  64'hFFFF_FFFF));
        dir_ops.push_back(make_op(OP_BFEXT, 1'b1, '1, 64'd0, 64'd0, 6'd0, 6'd63, 1'b0,
                                  64'd0));
        // empty mask
        dir_ops.push_back(make_op(OP_BFINS, 1'b1, 64'd0, '1, 64'd0, 6'd63, 6'd0, 1'b0,
                                  64'd0));
        dir_ops.push_back(make_op(OP_SELECT, 1'b1, 64'd1, 64'd2, 64'd0, 6'd0, 6'd0, 1'b1,
                                  64'd2));
        dir_ops.push_back(make_op(OP_SELECT, 1'b1, 64'd1, 64'd2, mn, 6'd0, 6'd0, 1'b1,
                                  64'd1));
        dir_ops.push_back(make_op(OP_MULHS, 1'b1, mn, mn, 64'd0, 6'd0, 6'd0, 1'b0, 64'd0));
        dir_ops.push_back(make_op(OP_MULHU, 1'b1, '1, '1, 64'd0, 6'd0, 6'd0, 1'b0, 64'd0));
        dir_ops.push_back(make_op(OP_SRA, 1'b0, 64'h8000_0000, 64'd63, 64'd0, 6'd0, 6'd0,
                                  1'b0, 64'd0));
        dir_ops.push_back(make_op(OP_ROL, 1'b1, 64'd1, 64'd65, 64'd0, 6'd0, 6'd0, 1'b0,
                                  64'd0));
        dir_ops.push_back(make_op(OP_SEXT16, 1'b0, 64'h8000, 64'd0, 64'd0, 6'd0, 6'd0,
                                  1'b1, 64'hFFFF_8000));
        // unused code
        dir_ops.push_back(make_op(OpUnused, 1'b1, '1, '1, '1, 6'd63, 6'd63, 1'b1, 64'd0));
        for (int i = 0; i < dir_ops.size(); i++)
            send_op(dir_ops[i]);

        // Random part in three idling phases
        for (int i = 0; i < NumRandom; i++)
        begin
            if (i == NumRandom / 3)
            begin
                send_idle_pct = 76; recv_idle_pct = 19;
            end
            if (i == 2 * NumRandom / 3)
            begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            n = $urandom_range(0, 99);
            t.op    = (n < 95) ? 6'($urandom_range(0, 33)) : 6'($urandom_range(34, 63));
            t.w64   = 1'($urandom);
            t.a     = rand64();
            t.b     = rand64();
            t.c     = ($urandom_range(0, 1) != 0) ? 64'd0 : rand64();
            t.start = 6'($urandom);
            t.count = 6'($urandom);
            t.has_exp = 1'b0;
            t.exp     = '0;
            send_op(t);
        end
        push <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
